>>> rtl/wst_pkg.sv
// Shared constants, types and helpers for the wrench statistics tracker.
// Depends on nothing; every other file imports it.
package wst_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int NUM_CH       = 8;
   localparam int CH_W         = 3;
   localparam int VAL_W        = SAMPLE_WIDTH + 2;      // signed channel value
   localparam int OUT_W        = 17;
   localparam int IDX_W        = 32;
   localparam int SUM_W        = 50;
   localparam int PROD_W       = 2 * SAMPLE_WIDTH;
   localparam int SQ_W         = 2 * SAMPLE_WIDTH + 2;  // sum of three squares
   localparam int ROOT_W       = SAMPLE_WIDTH + 1;
   localparam int ROOT_STEPS   = SQ_W / 2;
   localparam int DIV_STEPS    = SUM_W;
   localparam int CNT_W        = $clog2(DIV_STEPS + 1);
   localparam int NUM_SQ       = 6;

   localparam logic [CH_W-1:0] CH_FORCE_MAG  = 3'd6;
   localparam logic [CH_W-1:0] CH_TORQUE_MAG = 3'd7;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   localparam logic [IDX_W-1:0] COUNT_MAX = {IDX_W{1'b1}};

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_SQ   = 6'b000010,
      S_ROOT = 6'b000100,
      S_UPD  = 6'b001000,
      S_DIV  = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       capture;
      logic       mul_en;
      logic [2:0] mul_sel;
      logic       acc_en;
      logic       acc_sel;
      logic       root_init;
      logic       root_step;
      logic       update;
      logic       div_init;
      logic       div_step;
      logic       result_load;
   } ctl_type;

   // Status back to the controller
   typedef struct packed {
      logic count_zero;
   } sts_type;

   // Clamp a wide signed value to the 17-bit result range
   function automatic logic [OUT_W-1:0] clamp_out(input logic signed [SUM_W:0] v);
      logic signed [SUM_W:0] hi;
      logic signed [SUM_W:0] lo;
      hi = (SUM_W+1)'(65535);
      lo = -(SUM_W+1)'(65536);
      if (v > hi) begin
         clamp_out = OUT_W'(65535);
      end else if (v < lo) begin
         clamp_out = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         clamp_out = v[OUT_W-1:0];
      end
   endfunction

endpackage

>>> rtl/wrench_statistics_tracker_top.sv
// Sequence: a sample updates the stores after 6 squares, 17-step roots and the store update;
// a read result is loaded after the 50-step mean divider, or without the divider
// when no samples have been taken yet.
// Throughput: one word at a time, set by the divider and root loops.
// A finished result sits in the output register while the next word is taken.
// Reset (synchronous, active high) clears the sample count; stores fill on the first sample.
// Depends on wst_pkg, wst_ctrl and wst_datapath.
module wrench_statistics_tracker_top
   import wst_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_type,
   input  logic signed [SAMPLE_WIDTH-1:0] req_force_x,
   input  logic signed [SAMPLE_WIDTH-1:0] req_force_y,
   input  logic signed [SAMPLE_WIDTH-1:0] req_force_z,
   input  logic signed [SAMPLE_WIDTH-1:0] req_torque_x,
   input  logic signed [SAMPLE_WIDTH-1:0] req_torque_y,
   input  logic signed [SAMPLE_WIDTH-1:0] req_torque_z,
   input  logic [CH_W-1:0]                req_channel,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [OUT_W-1:0]        rsp_min_value,
   output logic signed [OUT_W-1:0]        rsp_max_value,
   output logic [IDX_W-1:0]               rsp_min_index,
   output logic [IDX_W-1:0]               rsp_max_index,
   output logic signed [OUT_W-1:0]        rsp_mean_value,
   output logic signed [OUT_W-1:0]        rsp_first_value,
   output logic signed [OUT_W-1:0]        rsp_last_value,
   output logic [IDX_W-1:0]               rsp_sample_count,
   output logic                           rsp_has_data
);
   ctl_type ctl;
   sts_type sts;
   logic signed [SAMPLE_WIDTH-1:0] samples [NUM_SQ];

   assign samples[0] = req_force_x;
   assign samples[1] = req_force_y;
   assign samples[2] = req_force_z;
   assign samples[3] = req_torque_x;
   assign samples[4] = req_torque_y;
   assign samples[5] = req_torque_z;

   wst_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .sts(sts), .ctl(ctl)
   );

   wst_datapath u_datapath (
      .clock(clock), .reset(reset), .ctl(ctl), .sts(sts),
      .in_sample(samples), .in_channel(req_channel),
      .min_value(rsp_min_value), .max_value(rsp_max_value),
      .min_index(rsp_min_index), .max_index(rsp_max_index),
      .mean_value(rsp_mean_value), .first_value(rsp_first_value),
      .last_value(rsp_last_value), .sample_count(rsp_sample_count),
      .has_data(rsp_has_data)
   );

`ifndef NO_ASSERTIONS
   // one word in flight: no back-to-back accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("word accepted while previous one in progress");

   // empty result carries a zero count
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_data) |-> (rsp_sample_count == '0))
      else $error("empty result with nonzero count");

   // minimum never above maximum
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_has_data) |-> (rsp_min_value <= rsp_max_value))
      else $error("minimum above maximum");
`endif
endmodule

>>> rtl/wst_sqrt.sv
// Iterative integer square root, two radicand bits per cycle while step is high.
// Depends on wst_pkg.
module wst_sqrt
   import wst_pkg::*;
(
   input  logic              clock,
   input  logic              init,
   input  logic              step,
   input  logic [SQ_W-1:0]   radicand,
   output logic [ROOT_W-1:0] root
);
   localparam int RW = ROOT_W + 3;

   logic [SQ_W-1:0]   n_ff, n_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [RW-1:0]     rem_shift;
   logic [RW:0]       trial;

   // Bring down two bits and try subtracting 4*root+1
   always_comb begin
      rem_shift = {rem_ff[RW-3:0], n_ff[SQ_W-1 -: 2]};
      trial     = {1'b0, rem_shift} - {2'b00, root_ff, 2'b01};
      n_in      = n_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      if (init) begin
         n_in    = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (step) begin
         n_in = {n_ff[SQ_W-3:0], 2'b00};
         if (!trial[RW]) begin
            rem_in  = trial[RW-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
endmodule

>>> rtl/wst_div.sv
// Restoring divider, one quotient bit per cycle while step is high, for the channel mean.
// Depends on wst_pkg.
module wst_div
   import wst_pkg::*;
(
   input  logic             clock,
   input  logic             init,
   input  logic             step,
   input  logic [SUM_W-1:0] dividend,
   input  logic [IDX_W-1:0] divisor,
   output logic [SUM_W-1:0] quotient
);
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0] den_ff, den_in;
   logic [IDX_W:0]   rem_shift;
   logic [IDX_W:0]   diff;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[SUM_W-1]};
      diff      = rem_shift - {1'b0, den_ff};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      if (init) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
      end else if (step) begin
         // partial remainder stays below the divisor
         if (rem_shift >= {1'b0, den_ff}) begin
            rem_in = diff[IDX_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[IDX_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
endmodule

>>> rtl/wst_datapath.sv
// Datapath: sample capture, squaring, magnitudes, per-channel stores, mean, result word.
// Depends on wst_pkg, wst_sqrt and wst_div.
module wst_datapath
   import wst_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  ctl_type                   ctl,
   output sts_type                   sts,
   input  logic signed [SAMPLE_WIDTH-1:0] in_sample [NUM_SQ],
   input  logic [CH_W-1:0]           in_channel,
   output logic signed [OUT_W-1:0]   min_value,
   output logic signed [OUT_W-1:0]   max_value,
   output logic [IDX_W-1:0]          min_index,
   output logic [IDX_W-1:0]          max_index,
   output logic signed [OUT_W-1:0]   mean_value,
   output logic signed [OUT_W-1:0]   first_value,
   output logic signed [OUT_W-1:0]   last_value,
   output logic [IDX_W-1:0]          sample_count,
   output logic                      has_data
);
   logic signed [SAMPLE_WIDTH-1:0] smp_ff [NUM_SQ];
   logic [CH_W-1:0]   ch_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [SQ_W-1:0]   acc_ff [2];
   logic [IDX_W-1:0]  count_ff, count_in;

   logic signed [VAL_W-1:0] min_ff   [NUM_CH];
   logic signed [VAL_W-1:0] max_ff   [NUM_CH];
   logic [IDX_W-1:0]        minix_ff [NUM_CH];
   logic [IDX_W-1:0]        maxix_ff [NUM_CH];
   logic signed [SUM_W-1:0] sum_ff   [NUM_CH];
   logic signed [VAL_W-1:0] first_ff [NUM_CH];
   logic signed [VAL_W-1:0] last_ff  [NUM_CH];

   logic signed [OUT_W-1:0] min_out_ff, max_out_ff, mean_out_ff, first_out_ff, last_out_ff;
   logic [IDX_W-1:0]        minix_out_ff, maxix_out_ff, count_out_ff;
   logic                    has_out_ff;

   logic [ROOT_W-1:0] root_f, root_t;
   logic [SUM_W-1:0]  quotient;
   logic signed [SAMPLE_WIDTH:0] mul_x;
   logic [SAMPLE_WIDTH-1:0]      mul_mag;
   logic signed [VAL_W-1:0]      val [NUM_CH];
   logic signed [SUM_W-1:0]      sel_sum;
   logic [SUM_W-1:0]             sum_mag;
   logic                         sum_neg;
   logic signed [SUM_W:0]        mean_wide;
   logic                         first_smp, counting;

   // Magnitude units, one per group
   wst_sqrt u_sqrt_force (
      .clock(clock), .init(ctl.root_init), .step(ctl.root_step),
      .radicand(acc_ff[0]), .root(root_f)
   );
   wst_sqrt u_sqrt_torque (
      .clock(clock), .init(ctl.root_init), .step(ctl.root_step),
      .radicand(acc_ff[1]), .root(root_t)
   );

   // Mean of the selected channel
   assign sel_sum = sum_ff[ch_ff];
   assign sum_neg = sel_sum[SUM_W-1];
   assign sum_mag = sum_neg ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);

   wst_div u_div (
      .clock(clock), .init(ctl.div_init), .step(ctl.div_step),
      .dividend(sum_mag), .divisor(count_ff), .quotient(quotient)
   );

   assign mean_wide = sum_neg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});

   // Squaring operand
   assign mul_x   = {smp_ff[ctl.mul_sel][SAMPLE_WIDTH-1], smp_ff[ctl.mul_sel]};
   assign mul_mag = mul_x[SAMPLE_WIDTH] ? SAMPLE_WIDTH'(-mul_x) : SAMPLE_WIDTH'(mul_x);

   // Channel values
   always_comb begin
      for (int c = 0; c < NUM_SQ; c++) begin
         val[c] = VAL_W'(smp_ff[c]);
      end
      val[CH_FORCE_MAG]  = $signed({1'b0, root_f});
      val[CH_TORQUE_MAG] = $signed({1'b0, root_t});
   end

   assign first_smp = (count_ff == '0);
   assign counting  = (count_ff != COUNT_MAX);
   assign count_in  = (ctl.update && counting) ? count_ff + IDX_W'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Capture, squaring and accumulation
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         smp_ff    <= in_sample;
         ch_ff     <= in_channel;
         acc_ff[0] <= '0;
         acc_ff[1] <= '0;
      end else if (ctl.acc_en) begin
         acc_ff[ctl.acc_sel] <= acc_ff[ctl.acc_sel] + SQ_W'(prod_ff);
      end
      if (ctl.mul_en) begin
         prod_ff <= mul_mag * mul_mag;
      end
   end

   // Per-channel statistics update
   always_ff @(posedge clock) begin
      if (ctl.update) begin
         for (int c = 0; c < NUM_CH; c++) begin
            logic signed [SUM_W:0] s;
            s = $signed({sum_ff[c][SUM_W-1], sum_ff[c]}) + (SUM_W+1)'(val[c]);
            if (first_smp) begin
               min_ff[c]   <= val[c];
               max_ff[c]   <= val[c];
               minix_ff[c] <= count_ff;
               maxix_ff[c] <= count_ff;
               first_ff[c] <= val[c];
               sum_ff[c]   <= SUM_W'(val[c]);
            end else begin
               if (val[c] > max_ff[c]) begin
                  max_ff[c]   <= val[c];
                  maxix_ff[c] <= count_ff;
               end else if (val[c] < min_ff[c]) begin
                  min_ff[c]   <= val[c];
                  minix_ff[c] <= count_ff;
               end
               if (counting) begin
                  // clamp to the signed sum range
                  if (s[SUM_W] != s[SUM_W-1]) begin
                     sum_ff[c] <= {s[SUM_W], {(SUM_W-1){~s[SUM_W]}}};
                  end else begin
                     sum_ff[c] <= s[SUM_W-1:0];
                  end
               end
            end
            last_ff[c] <= val[c];
         end
      end
   end

   // Result word
   always_ff @(posedge clock) begin
      if (ctl.result_load) begin
         if (first_smp) begin
            min_out_ff   <= '0;
            max_out_ff   <= '0;
            minix_out_ff <= '0;
            maxix_out_ff <= '0;
            mean_out_ff  <= '0;
            first_out_ff <= '0;
            last_out_ff  <= '0;
            count_out_ff <= '0;
            has_out_ff   <= 1'b0;
         end else begin
            min_out_ff   <= clamp_out((SUM_W+1)'(min_ff[ch_ff]));
            max_out_ff   <= clamp_out((SUM_W+1)'(max_ff[ch_ff]));
            minix_out_ff <= minix_ff[ch_ff];
            maxix_out_ff <= maxix_ff[ch_ff];
            mean_out_ff  <= clamp_out(mean_wide);
            first_out_ff <= clamp_out((SUM_W+1)'(first_ff[ch_ff]));
            last_out_ff  <= clamp_out((SUM_W+1)'(last_ff[ch_ff]));
            count_out_ff <= count_ff;
            has_out_ff   <= 1'b1;
         end
      end
   end

   assign sts.count_zero = first_smp;
   assign min_value    = min_out_ff;
   assign max_value    = max_out_ff;
   assign min_index    = minix_out_ff;
   assign max_index    = maxix_out_ff;
   assign mean_value   = mean_out_ff;
   assign first_value  = first_out_ff;
   assign last_value   = last_out_ff;
   assign sample_count = count_out_ff;
   assign has_data     = has_out_ff;
endmodule

>>> rtl/wst_ctrl.sv
// Controller: sequences squaring, square roots, store update, division and result handoff.
// Depends on wst_pkg.
module wst_ctrl
   import wst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    req_type,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output ctl_type ctl
);
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept, out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff + CNT_W'(1);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl          = '0;
      ctl.capture  = accept;
      ctl.mul_sel  = cnt_ff[2:0];
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               if (req_type == REQ_SAMPLE) begin
                  state_in = S_SQ;
               end else if (sts.count_zero) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         // one square per cycle, added to its sum in the next cycle
         S_SQ: begin
            ctl.mul_en  = (cnt_ff < CNT_W'(NUM_SQ));
            ctl.acc_en  = (cnt_ff != '0);
            ctl.acc_sel = (cnt_ff > CNT_W'(3));
            if (cnt_ff == CNT_W'(NUM_SQ)) begin
               state_in = S_ROOT;
               cnt_in   = '0;
            end
         end
         S_ROOT: begin
            ctl.root_init = (cnt_ff == '0);
            ctl.root_step = (cnt_ff != '0);
            if (cnt_ff == CNT_W'(ROOT_STEPS)) begin
               state_in = S_UPD;
               cnt_in   = '0;
            end
         end
         S_UPD: begin
            ctl.update = 1'b1;
            state_in   = S_IDLE;
         end
         S_DIV: begin
            ctl.div_init = (cnt_ff == '0);
            ctl.div_step = (cnt_ff != '0);
            if (cnt_ff == CNT_W'(DIV_STEPS)) begin
               state_in = S_OUT;
               cnt_in   = '0;
            end
         end
         S_OUT: begin
            if (out_free) begin
               ctl.result_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
